[sv/cdb_pkg.sv]
// cdb_pkg: shared widths, register indexes, reset values and sequencer states
`default_nettype none
package cdb_pkg;

   localparam int CoordWidth  = 21;
   localparam int SizeWidth   = 13;
   localparam int BrightWidth = 8;
   localparam int CornerWidth = 2;
   localparam int NumCorners  = 4;
   localparam int CsrIdxWidth = 3;
   localparam int CsrWidth    = CoordWidth;

   localparam int PosWidth    = CoordWidth + 2;
   localparam int DiffWidth   = PosWidth + 1;
   localparam int AbsWidth    = CoordWidth + 1;
   localparam int SqWidth     = 2 * AbsWidth;
   localparam int RadWidth    = SqWidth + 2;
   localparam int RootWidth   = RadWidth / 2;
   localparam int RemWidth    = RootWidth + 2;
   localparam int TrialWidth  = RemWidth + 2;
   localparam int StepWidth   = 5;

   typedef logic signed [CoordWidth-1:0] coord_type;
   typedef logic [SizeWidth-1:0]         size_type;
   typedef logic [BrightWidth-1:0]       bright_type;
   typedef logic [CornerWidth-1:0]       corner_type;
   typedef logic [CsrIdxWidth-1:0]       csr_idx_type;
   typedef logic [CsrWidth-1:0]          csr_data_type;

   localparam csr_idx_type RegTileLeft   = 3'd0;
   localparam csr_idx_type RegTileTop    = 3'd1;
   localparam csr_idx_type RegTileSize   = 3'd2;
   localparam csr_idx_type RegSourceOffX = 3'd3;
   localparam csr_idx_type RegSourceOffY = 3'd4;
   localparam csr_idx_type RegMaxBright  = 3'd5;

   localparam corner_type CornerTopLeft     = 2'd0;
   localparam corner_type CornerTopRight    = 2'd1;
   localparam corner_type CornerBottomRight = 2'd2;
   localparam corner_type CornerBottomLeft  = 2'd3;

   localparam size_type   TileSizeReset   = 13'd32;
   localparam size_type   SourceOffXReset = 13'd16;
   localparam size_type   SourceOffYReset = 13'd32;
   localparam bright_type MaxBrightReset  = 8'd255;

   typedef enum logic [5:0] {
      ST_IDLE = 6'b000001,
      ST_DIFF = 6'b000010,
      ST_SQX  = 6'b000100,
      ST_SQY  = 6'b001000,
      ST_ROOT = 6'b010000,
      ST_DONE = 6'b100000
   } state_type;

endpackage
`default_nettype wire

[sv/cdb_if.sv]
// cdb request and response channel interfaces
`default_nettype none
interface cdb_req_if;
   import cdb_pkg::*;
   logic       valid;
   logic       ready;
   coord_type  player_x;
   coord_type  player_y;
   corner_type corner;
   modport source (output valid, player_x, player_y, corner, input ready);
   modport sink (input valid, player_x, player_y, corner, output ready);
endinterface

interface cdb_rsp_if;
   import cdb_pkg::*;
   logic       valid;
   logic       ready;
   bright_type brightness;
   modport source (output valid, brightness, input ready);
   modport sink (input valid, brightness, output ready);
endinterface
`default_nettype wire

[sv/corner_distance_brightness.sv]
// corner_distance_brightness: corner light falloff by distance with a bit-serial square root
//
//   channel   dir   signals                              beat taken when
//   req_ch    in    player_x, player_y, corner           valid && ready
//   rsp_ch    out   brightness                           valid && ready
//   csr_*     in    csr_we, csr_index, csr_wdata         csr_we high
//
// an item is taken only in idle and passes through capture, the distance differences,
// x then y on the shared squaring multiplier, the two-bits-per-cycle restoring square
// root unit, and the clamp and store update before the next item is accepted.
// reset is synchronous; it resets control and config and clears the four corner brightnesses.
// a result waits in the output register; the clamp step holds until it is taken.
`default_nettype none
module corner_distance_brightness (
   input  wire                    clock,
   input  wire                    reset,
   cdb_req_if.sink                req_ch,
   cdb_rsp_if.source              rsp_ch,
   input  wire                    csr_we,
   input  wire cdb_pkg::csr_idx_type  csr_index,
   input  wire cdb_pkg::csr_data_type csr_wdata
);
   import cdb_pkg::*;

   state_type state_ff, state_in;

   coord_type  tile_left_ff, tile_top_ff;
   size_type   tile_size_ff, off_x_ff, off_y_ff;
   bright_type max_bright_ff;

   bright_type corner_bright_ff [NumCorners];

   coord_type  px_ff, py_ff;
   corner_type corner_ff;

   logic [AbsWidth-1:0]   dx_ff, dy_ff;
   logic [RadWidth-1:0]   rad_ff, rad_in;
   logic [RootWidth-1:0]  root_ff, root_in;
   logic [RemWidth-1:0]   rem_ff, rem_in;
   logic [StepWidth-1:0]  step_ff, step_in;

   logic       rsp_valid_ff, rsp_valid_in;
   bright_type rsp_bright_ff;

   // distance differences
   logic signed [PosWidth-1:0]  sx, sy, cx, cy;
   logic signed [DiffWidth-1:0] ddx, ddy;
   logic [DiffWidth-1:0]        adx, ady;
   logic                        add_x, add_y;

   always_comb begin
      add_x = (corner_ff == CornerTopRight) || (corner_ff == CornerBottomRight);
      add_y = (corner_ff == CornerBottomRight) || (corner_ff == CornerBottomLeft);
      sx = PosWidth'(px_ff) + $signed({{(PosWidth-SizeWidth){1'b0}}, off_x_ff});
      sy = PosWidth'(py_ff) + $signed({{(PosWidth-SizeWidth){1'b0}}, off_y_ff});
      cx = PosWidth'(tile_left_ff)
         + $signed({{(PosWidth-SizeWidth){1'b0}}, (add_x ? tile_size_ff : '0)});
      cy = PosWidth'(tile_top_ff)
         + $signed({{(PosWidth-SizeWidth){1'b0}}, (add_y ? tile_size_ff : '0)});
      ddx = DiffWidth'(sx) - DiffWidth'(cx);
      ddy = DiffWidth'(sy) - DiffWidth'(cy);
      adx = ddx[DiffWidth-1] ? DiffWidth'(-ddx) : DiffWidth'(ddx);
      ady = ddy[DiffWidth-1] ? DiffWidth'(-ddy) : DiffWidth'(ddy);
   end

   // shared squaring multiplier
   logic [AbsWidth-1:0] sq_op;
   logic [SqWidth-1:0]  sq_prod;

   always_comb begin
      sq_op   = state_ff[$clog2(ST_SQY)] ? dy_ff : dx_ff;
      sq_prod = sq_op * sq_op;
   end

   // square root step
   logic [TrialWidth-1:0] rem_sh, trial;
   logic                  ge;

   always_comb begin
      rem_sh = {rem_ff, rad_ff[RadWidth-1 -: 2]};
      trial  = {2'b00, root_ff, 2'b01};
      ge     = rem_sh >= trial;
   end

   // clamp against the maximum and the stored value
   bright_type stored, cand, result;
   logic       in_reach;

   always_comb begin
      stored   = corner_bright_ff[corner_ff];
      in_reach = root_ff <= RootWidth'(max_bright_ff);
      cand     = max_bright_ff - root_ff[BrightWidth-1:0];
      result   = (in_reach && (cand > stored)) ? cand : stored;
   end

   logic rsp_free;
   assign rsp_free = !rsp_valid_ff || rsp_ch.ready;

   always_comb begin
      state_in     = state_ff;
      rad_in       = rad_ff;
      root_in      = root_ff;
      rem_in       = rem_ff;
      step_in      = step_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (req_ch.valid) begin
               state_in = ST_DIFF;
            end
         end
         ST_DIFF: state_in = ST_SQX;
         ST_SQX: begin
            rad_in   = RadWidth'(sq_prod);
            state_in = ST_SQY;
         end
         ST_SQY: begin
            rad_in   = rad_ff + RadWidth'(sq_prod);
            root_in  = '0;
            rem_in   = '0;
            step_in  = StepWidth'(RootWidth - 1);
            state_in = ST_ROOT;
         end
         ST_ROOT: begin
            rad_in  = {rad_ff[RadWidth-3:0], 2'b00};
            rem_in  = ge ? RemWidth'(rem_sh - trial) : RemWidth'(rem_sh);
            root_in = {root_ff[RootWidth-2:0], ge};
            step_in = step_ff - 1'b1;
            if (step_ff == '0) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign req_ch.ready      = state_ff == ST_IDLE;
   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.brightness = rsp_bright_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_valid_ff  <= 1'b0;
         tile_left_ff  <= '0;
         tile_top_ff   <= '0;
         tile_size_ff  <= TileSizeReset;
         off_x_ff      <= SourceOffXReset;
         off_y_ff      <= SourceOffYReset;
         max_bright_ff <= MaxBrightReset;
         for (int i = 0; i < NumCorners; i++) begin
            corner_bright_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            unique case (csr_index)
               RegTileLeft:   tile_left_ff  <= coord_type'(csr_wdata);
               RegTileTop:    tile_top_ff   <= coord_type'(csr_wdata);
               RegTileSize:   tile_size_ff  <= csr_wdata[SizeWidth-1:0];
               RegSourceOffX: off_x_ff      <= csr_wdata[SizeWidth-1:0];
               RegSourceOffY: off_y_ff      <= csr_wdata[SizeWidth-1:0];
               RegMaxBright:  max_bright_ff <= csr_wdata[BrightWidth-1:0];
               default: ;
            endcase
         end
         if ((state_ff == ST_DONE) && rsp_free) begin
            corner_bright_ff[corner_ff] <= result;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_ch.valid && req_ch.ready) begin
         px_ff     <= req_ch.player_x;
         py_ff     <= req_ch.player_y;
         corner_ff <= req_ch.corner;
      end
      if (state_ff == ST_DIFF) begin
         dx_ff <= adx[AbsWidth-1:0];
         dy_ff <= ady[AbsWidth-1:0];
      end
      rad_ff  <= rad_in;
      root_ff <= root_in;
      rem_ff  <= rem_in;
      step_ff <= step_in;
      if ((state_ff == ST_DONE) && rsp_free) begin
         rsp_bright_ff <= result;
      end
   end

endmodule
`default_nettype wire
